/* rtl/idreg_pkg.sv */
// idreg_pkg: shared types and codes for the identifier registry table
// operation and status codes, controller/datapath command and status structs
// no dependencies
`default_nettype none

package idreg_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned ID_W   = 22;
  localparam int unsigned STAT_W = 3;

  // operation codes carried on func
  localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CHECK  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  // result codes carried on status
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_ALREADY = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STAT_W-1:0] ST_PRESENT = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the request and reset the search
    logic scan;    // read the slot at the scan address and step it
    logic commit;  // update the table and post the result
  } idreg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last; // scan address is at the final slot
    logic res_free;  // the result, if any, can be posted now
  } idreg_stat_t;

endpackage

`default_nettype wire

/* rtl/idreg_ctrl.sv */
// idreg_ctrl: sequencer for one request at a time (load, scan, drain, commit)
// depends on idreg_pkg for the command and status structs
`default_nettype none

module idreg_ctrl
  import idreg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  idreg_stat_t stat,
  output idreg_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (stat.res_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // decoded commands
  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.commit = (state == S_FINISH) && stat.res_free;

endmodule

`default_nettype wire

/* rtl/idreg_dp.sv */
// idreg_dp: slot memory with valid bits, scan read, match/empty tracking,
// table update and the result register; depends on idreg_pkg
`default_nettype none

module idreg_dp
  import idreg_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  idreg_cmd_t        cmd,
  output idreg_stat_t       stat,
  input  logic [FUNC_W-1:0] func,
  input  logic [ID_W-1:0]   ident,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [ID_W-1:0]      mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld;

  logic [FUNC_W-1:0] req_func;
  logic [ID_W-1:0]   req_id;
  logic [IDX_W-1:0]  addr;

  logic              rd_en;
  logic              rd_vld;
  logic [ID_W-1:0]   rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic [ID_W-1:0]   cur;

  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              empty_found;
  logic [IDX_W-1:0]  empty_idx;

  logic              need_res;
  logic              do_insert;
  logic              do_clear;
  logic [STAT_W-1:0] res_code;

  // request capture: operation held idle through reset
  always_ff @(posedge clk) begin
    if (rst) begin
      req_func <= FN_UNUSED;
    end else if (cmd.load) begin
      req_func <= func;
    end
  end

  // request capture, identifier only
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_id <= ident;
    end
  end

  // scan address
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.load) begin
      addr <= '0;
    end else if (cmd.scan) begin
      addr <= addr + IDX_W'(1);
    end
  end

  assign stat.scan_last = (addr == LAST_IDX);

  // slot memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data <= mem[addr];
      rd_idx  <= addr;
    end
    if (do_insert) begin
      mem[empty_idx] <= req_id;
    end
  end

  // read strobe, entry valid flag and per-slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en  <= 1'b0;
      rd_vld <= 1'b0;
      vld    <= '0;
    end else begin
      rd_en  <= cmd.scan;
      rd_vld <= vld[addr];
      if (do_insert) vld[empty_idx] <= 1'b1;
      if (do_clear)  vld[match_idx] <= 1'b0;
    end
  end

  // an entry never written, or removed, reads as empty
  assign cur = rd_vld ? rd_data : '0;

  // first match and first empty slot, lowest index wins
  always_ff @(posedge clk) begin
    if (rst) begin
      match_found <= 1'b0;
      empty_found <= 1'b0;
    end else if (cmd.load) begin
      match_found <= 1'b0;
      empty_found <= 1'b0;
    end else if (rd_en) begin
      if (!match_found && (cur == req_id)) begin
        match_found <= 1'b1;
        match_idx   <= rd_idx;
      end
      if (!empty_found && (cur == '0)) begin
        empty_found <= 1'b1;
        empty_idx   <= rd_idx;
      end
    end
  end

  // outcome of the finished search
  always_comb begin
    need_res  = 1'b0;
    do_insert = 1'b0;
    do_clear  = 1'b0;
    res_code  = ST_ABSENT;
    unique case (req_func)
      FN_ADD: begin
        need_res = 1'b1;
        if (match_found) begin
          res_code = ST_ALREADY;
        end else if (empty_found) begin
          res_code  = ST_ADDED;
          do_insert = cmd.commit;
        end else begin
          res_code = ST_FULL;
        end
      end
      FN_CHECK: begin
        need_res = 1'b1;
        res_code = match_found ? ST_PRESENT : ST_ABSENT;
      end
      FN_REMOVE: begin
        do_clear = cmd.commit && match_found;
      end
      FN_UNUSED: begin
        need_res = 1'b0;
      end
      default: need_res = 1'b0;
    endcase
  end

  assign stat.res_free = !need_res || !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && need_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && need_res) begin
      status <= res_code;
    end
  end

endmodule

`default_nettype wire

/* rtl/id_registry_table.sv */
// id_registry_table: top level joining the sequencer and the slot datapath
// depends on idreg_pkg, idreg_ctrl and idreg_dp
//
//   channel   signals                            direction
//   request   in_valid, in_ready, func, ident    in
//   result    out_valid, out_ready, status       out
//
// one request at a time: accept, a scan of all NUM_SLOTS slots through
// the single memory read port, a drain step, then the commit step.
// the result register lets a new request in while the last result waits;
// commit holds only when a new result meets a result not yet taken.
// synchronous reset clears the slot valid bits at once: every slot is empty.
`default_nettype none

module id_registry_table
  import idreg_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] func,
  input  logic [ID_W-1:0]   ident,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status
);

  idreg_cmd_t  cmd;
  idreg_stat_t stat;

  // sequencer
  idreg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table and result register
  idreg_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .func      (func),
    .ident     (ident),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status)
  );

  // only one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another was in progress");

  // commands are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("more than one command at once");

  // a posted result always carries a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_ADDED || status == ST_ALREADY || status == ST_FULL ||
                   status == ST_ABSENT || status == ST_PRESENT))
    else $error("result with undefined status code");

  // a commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(status) && out_valid))
    else $error("waiting result was overwritten or dropped");

endmodule

`default_nettype wire

/* sim/tb_id_registry_table.sv */
`timescale 1ns / 100ps
// tb_id_registry_table: self-checking bench for the identifier registry table
// keeps a shadow copy of the slots, updated on add and remove, to predict add and check statuses
// depends on idreg_pkg and id_registry_table

module tb_id_registry_table;
  import idreg_pkg::*;

  localparam int unsigned NUM_SLOTS  = 16;
  localparam int unsigned LATENCY    = NUM_SLOTS + 3;
  localparam int unsigned RAND_ITEMS = 1600;
  localparam int unsigned POOL_N     = 20;
  localparam int unsigned HOLD_AT    = 420;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned MAX_CYCLES = 1000000;
  localparam int unsigned MAX_PRINTS = 30;

  // one queued request plus the idle cycles offered before it
  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [ID_W-1:0]   id;
    int unsigned       gap;
    bit                drain;
  } request_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FUNC_W-1:0] func = FN_UNUSED;
  logic [ID_W-1:0]   ident = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;

  request_t          pending_q[$];
  logic [STAT_W-1:0] status_due[$];
  logic [ID_W-1:0]   shadow_slots[NUM_SLOTS];
  logic [ID_W-1:0]   id_pool[POOL_N];
  int unsigned       requests_taken = 0;
  int unsigned       results_seen = 0;
  int unsigned       status_count[5];
  int unsigned       error_count = 0;
  int unsigned       cycle_cnt = 0;

  id_registry_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .ident    (ident),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status)
  );

  always #5 clk = ~clk;

  // shadow table update, returns the status a request should produce
  function automatic void registry_predict(input logic [FUNC_W-1:0] op,
                                           input logic [ID_W-1:0] id,
                                           output bit gives,
                                           output logic [STAT_W-1:0] st);
    int hit;
    int empty_at;
    hit = -1;
    empty_at = -1;
    gives = 1'b0;
    st = ST_ADDED;
    // lowest matching slot and lowest empty slot
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (shadow_slots[i] == id) hit = i;
      if (shadow_slots[i] == '0) empty_at = i;
    end
    case (op)
      FN_ADD: begin
        gives = 1'b1;
        if (hit >= 0) begin
          st = ST_ALREADY;
        end else if (empty_at >= 0) begin
          shadow_slots[empty_at] = id;
          st = ST_ADDED;
        end else begin
          st = ST_FULL;
        end
      end
      FN_CHECK: begin
        gives = 1'b1;
        st = (hit >= 0) ? ST_PRESENT : ST_ABSENT;
      end
      FN_REMOVE: begin
        if (hit >= 0) shadow_slots[hit] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic queue_request(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] id,
                               input int unsigned gap, input bit drain);
    request_t r;
    r.op = op;
    r.id = id;
    r.gap = gap;
    r.drain = drain;
    pending_q.push_back(r);
  endtask

  // identifiers mostly from a small pool so that adds, checks and removes meet
  function automatic logic [ID_W-1:0] pick_ident();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return id_pool[$urandom_range(POOL_N - 1)];
    if (r < 85) return ID_W'($urandom);
    if (r < 92) return '0;
    return '1;
  endfunction

  // operation mix depends on the phase: filling, emptying or mixed
  function automatic logic [FUNC_W-1:0] pick_op(input int unsigned phase);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return FN_UNUSED;
    case (phase)
      0: return (r < 65) ? FN_ADD : (r < 88) ? FN_CHECK : FN_REMOVE;
      1: return (r < 22) ? FN_ADD : (r < 45) ? FN_CHECK : FN_REMOVE;
      default: return (r < 45) ? FN_ADD : (r < 72) ? FN_CHECK : FN_REMOVE;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stimulus: directed corner cases then phased random traffic
  initial begin : stimulus
    logic [FUNC_W-1:0] op;
    int unsigned counted;
    int unsigned idx;
    int unsigned phase;
    int unsigned gap;

    foreach (status_count[i]) status_count[i] = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(1, 2000));
    id_pool[0] = '1;
    id_pool[1] = 22'h000001;
    id_pool[2] = 22'h200000;

    // zero matches empty slots on an empty table
    queue_request(FN_ADD, '0, 0, 1'b0);
    queue_request(FN_CHECK, '0, 0, 1'b0);
    queue_request(FN_CHECK, '1, 0, 1'b0);
    queue_request(FN_REMOVE, '1, 1, 1'b0);
    queue_request(FN_ADD, '1, 0, 1'b0);
    queue_request(FN_ADD, '1, 0, 1'b0);
    queue_request(FN_CHECK, '1, 2, 1'b0);
    queue_request(FN_REMOVE, '0, 0, 1'b0);
    queue_request(FN_UNUSED, '1, 0, 1'b0);
    // fill every remaining slot
    for (int i = 1; i < NUM_SLOTS; i++) begin
      queue_request(FN_ADD, (ID_W'(1) << (i + 5)) | ID_W'(i), 0, 1'b0);
    end
    // full table: zero no longer matches, new adds are refused until a remove frees a slot
    queue_request(FN_ADD, '0, 0, 1'b0);
    queue_request(FN_CHECK, '0, 0, 1'b0);
    queue_request(FN_ADD, 22'h2AAAAA, 0, 1'b0);
    queue_request(FN_REMOVE, '1, 0, 1'b0);
    queue_request(FN_CHECK, '1, 0, 1'b0);
    queue_request(FN_ADD, 22'h155555, 0, 1'b0);

    // random part, ignored operations not counted
    counted = 0;
    idx = 0;
    while (counted < RAND_ITEMS) begin
      phase = (idx / 100) % 3;
      op = pick_op(phase);
      gap = pick_gap();
      if ((idx / 100) % 5 == 4 || (idx >= 400 && idx < 500)) gap = 0;
      queue_request(op, pick_ident(), gap, idx == 0 || idx == 800 || idx == 1200);
      if (op != FN_UNUSED) counted++;
      idx++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait until all requests are taken and every result has come back
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || status_due.size() != 0);
    repeat (3 * LATENCY) @(posedge clk);

    $display("requests taken: %0d, results checked: %0d, errors: %0d",
             requests_taken, results_seen, error_count);
    $display("status mix: added %0d, already %0d, full %0d, absent %0d, present %0d",
             status_count[ST_ADDED], status_count[ST_ALREADY], status_count[ST_FULL],
             status_count[ST_ABSENT], status_count[ST_PRESENT]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // request driver: predicts at acceptance, then offers the next request
  always @(posedge clk) begin : drive_requests
    bit gives;
    logic [STAT_W-1:0] st;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        registry_predict(func, ident, gives, st);
        if (gives) status_due.push_back(st);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && pending_q[0].gap != 0) begin
          pending_q[0].gap = pending_q[0].gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && status_due.size() != 0)) begin
          func     <= pending_q[0].op;
          ident    <= pending_q[0].id;
          in_valid <= 1'b1;
          pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result ready: random stalls, calm stretches and one long hold-off
  always @(posedge clk) begin : drive_ready
    int unsigned stall_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned r;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && requests_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if ((cycle_cnt / 2000) % 5 == 0 || r < 65) begin
        out_ready <= 1'b1;
      end else if (r < 93) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        stall_left = $urandom_range(15, 60);
        out_ready <= 1'b0;
      end
    end
  end

  // result monitor: compare each status with the oldest expectation
  always @(posedge clk) begin : check_results
    logic [STAT_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (status <= ST_PRESENT) status_count[status]++;
      if (status_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_PRINTS)
          $display("%0t: unexpected result, expected none, actual status %0d",
                   $time, status);
      end else begin
        want = status_due.pop_front();
        if (status !== want) begin
          error_count++;
          if (error_count <= MAX_PRINTS)
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want, status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_cnt, status_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
